FILE: hw/rtl/hlfc_pkg.sv
// Shared constants, types and helper functions for the Hough line frame clipper.
package hlfc_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int COORD_WIDTH  = 16;

   localparam int XY_W  = 34;
   localparam int Z_W   = 33;
   localparam int NUM_W = 48;
   localparam int DEN_W = 32;
   localparam int Q_W   = 33;
   localparam int HEAD_W = NUM_W - Q_W;
   localparam int DIV_STEPS = Q_W;
   localparam int EP_W  = 36;

   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [11:0] FRAME_HEIGHT_RESET = 12'd480;

   localparam logic signed [XY_W-1:0] CORDIC_X_START = 34'sh026DD3B6B;

   localparam logic signed [31:0] VERT_SLOPE     = 32'sd655294464;
   localparam logic signed [23:0] VERT_INTERCEPT = -24'sd159984;

   localparam logic signed [31:0] SLOPE_MAX     = 32'sh7FFFFFFF;
   localparam logic signed [31:0] SLOPE_MIN     = 32'sh80000000;
   localparam logic signed [23:0] INTERCEPT_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] INTERCEPT_MIN = 24'sh800000;

   localparam logic signed [EP_W-1:0] COORD_MAX = EP_W'(2**COORD_WIDTH - 1);

   typedef logic signed [EP_W-1:0] ep_type;

   typedef struct packed {
      logic [16:0] r;
      logic        vert;
      logic        vhit;
   } cordic_side_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   flip;
      cordic_side_type        side;
   } cordic_data_type;

   typedef struct packed {
      logic [16:0]        r;
      logic               vert;
      logic               vhit;
      logic               s_zero;
      logic               c_pos;
      logic               c_zero;
      logic signed [31:0] m;
      logic signed [23:0] b;
      logic signed [33:0] y_w;
   } div_side_type;

   typedef struct packed {
      logic [NUM_W-1:0] n0_mag;
      logic             n0_neg;
      logic [NUM_W-1:0] n1_mag;
      logic             n1_neg;
      logic [DEN_W-1:0] d;
      div_side_type     side;
   } div_request_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [Q_W-1:0]   low;
      logic [Q_W-1:0]   q;
      logic             ovf;
      logic             neg;
   } div_lane_type;

   typedef struct packed {
      logic [Q_W-1:0] q;
      logic           ovf;
      logic           neg;
   } div_result_type;

   typedef struct packed {
      div_result_type r0;
      div_result_type r1;
      div_side_type   side;
   } div_response_type;

   typedef struct packed {
      logic m_zero;
      logic m_pos;
      logic b_neg;
      logic b_gt_h;
      logic yw_gt_h;
      logic xh_gt_w;
      logic x0_gt_w;
   } clip_flags_type;

   // Arctangent of 2^-i as a 32-bit binary angle.
   function automatic logic [31:0] atan_entry(input int i);
      logic [31:0] v;
      case (i)
         0:  v = 32'h20000000;
         1:  v = 32'h12E4051D;
         2:  v = 32'h09FB385B;
         3:  v = 32'h051111D4;
         4:  v = 32'h028B0D43;
         5:  v = 32'h0145D7E1;
         6:  v = 32'h00A2F61E;
         7:  v = 32'h00517C55;
         8:  v = 32'h0028BE53;
         9:  v = 32'h00145F2E;
         10: v = 32'h000A2F98;
         11: v = 32'h000517CC;
         12: v = 32'h00028BE6;
         13: v = 32'h000145F3;
         14: v = 32'h0000A2F9;
         15: v = 32'h0000517C;
         16: v = 32'h000028BE;
         17: v = 32'h0000145F;
         18: v = 32'h00000A2F;
         19: v = 32'h00000517;
         20: v = 32'h0000028B;
         21: v = 32'h00000145;
         22: v = 32'h000000A2;
         23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

   // Signed quotient from a divider lane; an overflowed quotient becomes a large value.
   function automatic ep_type div_to_ep(input div_result_type r);
      logic [Q_W:0]    mag;
      logic [EP_W-1:0] v;
      mag = r.ovf ? {1'b1, {Q_W{1'b0}}} : {1'b0, r.q};
      v   = r.neg ? (EP_W'(0) - EP_W'(mag)) : EP_W'(mag);
      return signed'(v);
   endfunction

   // Endpoint clamp to the coordinate range, keeping the low 16 bits.
   function automatic logic [15:0] coord_clip(input ep_type v);
      logic [15:0] c;
      if (v < 0) begin
         c = 16'd0;
      end else if (v > COORD_MAX) begin
         c = COORD_MAX[15:0];
      end else begin
         c = v[15:0];
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/hlfc_cordic.sv
// Rotation-mode CORDIC pipeline, one iteration per register stage.
module hlfc_cordic (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [15:0]               in_theta,
   input  hlfc_pkg::cordic_side_type in_side,
   output logic                      out_valid,
   output hlfc_pkg::cordic_data_type out_data
);

   logic                      valid_ff [hlfc_pkg::CORDIC_STEPS];
   hlfc_pkg::cordic_data_type data_ff  [hlfc_pkg::CORDIC_STEPS];
   hlfc_pkg::cordic_data_type start;
   logic [31:0]               za;

   // Fold the angle into the right half plane; the flip flag marks a result that is to be read negated.
   always_comb begin
      start      = '0;
      start.flip = in_theta[15] ^ in_theta[14];
      za         = {in_theta[15] ^ start.flip, in_theta[14:0], 16'h0000};
      start.x    = hlfc_pkg::CORDIC_X_START;
      start.y    = '0;
      start.z    = hlfc_pkg::Z_W'(signed'(za));
      start.side = in_side;
   end

   for (genvar i = 0; i < hlfc_pkg::CORDIC_STEPS; i++) begin : g_step
      hlfc_pkg::cordic_data_type cur;
      hlfc_pkg::cordic_data_type nxt;
      logic                      cur_valid;
      logic signed [hlfc_pkg::XY_W-1:0] xs;
      logic signed [hlfc_pkg::XY_W-1:0] ys;
      logic signed [hlfc_pkg::Z_W-1:0]  at;

      if (i == 0) begin : g_first
         assign cur       = start;
         assign cur_valid = in_valid;
      end else begin : g_next
         assign cur       = data_ff[i-1];
         assign cur_valid = valid_ff[i-1];
      end

      assign xs = cur.x >>> i;
      assign ys = cur.y >>> i;
      assign at = signed'({1'b0, hlfc_pkg::atan_entry(i)});

      always_comb begin
         nxt = cur;
         if (!cur.z[hlfc_pkg::Z_W-1]) begin
            nxt.x = cur.x - ys;
            nxt.y = cur.y + xs;
            nxt.z = cur.z - at;
         end else begin
            nxt.x = cur.x + ys;
            nxt.y = cur.y - xs;
            nxt.z = cur.z + at;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            data_ff[i] <= nxt;
         end
      end
   end

   assign out_valid = valid_ff[hlfc_pkg::CORDIC_STEPS-1];
   assign out_data  = data_ff[hlfc_pkg::CORDIC_STEPS-1];

endmodule

FILE: hw/rtl/hlfc_div.sv
// Two-lane restoring divider with a shared divisor, one quotient bit per stage.
module hlfc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  hlfc_pkg::div_request_type  in_req,
   output logic                       out_valid,
   output hlfc_pkg::div_response_type out_rsp
);

   typedef struct packed {
      hlfc_pkg::div_lane_type       l0;
      hlfc_pkg::div_lane_type       l1;
      logic [hlfc_pkg::DEN_W-1:0]   d;
      hlfc_pkg::div_side_type       side;
   } stage_type;

   logic      valid_ff [hlfc_pkg::DIV_STEPS];
   stage_type data_ff  [hlfc_pkg::DIV_STEPS];
   stage_type start;

   function automatic hlfc_pkg::div_lane_type lane_init(
      input logic [hlfc_pkg::NUM_W-1:0] n,
      input logic                       neg,
      input logic [hlfc_pkg::DEN_W-1:0] d
   );
      hlfc_pkg::div_lane_type l;
      logic [hlfc_pkg::DEN_W-1:0] head;
      head  = hlfc_pkg::DEN_W'(n[hlfc_pkg::NUM_W-1:hlfc_pkg::Q_W]);
      l.rem = head;
      l.low = n[hlfc_pkg::Q_W-1:0];
      l.q   = '0;
      l.ovf = head >= d;
      l.neg = neg;
      return l;
   endfunction

   function automatic hlfc_pkg::div_lane_type lane_step(
      input hlfc_pkg::div_lane_type     l,
      input logic [hlfc_pkg::DEN_W-1:0] d
   );
      hlfc_pkg::div_lane_type n;
      logic [hlfc_pkg::DEN_W:0] t;
      logic                     ge;
      t     = {l.rem, l.low[hlfc_pkg::Q_W-1]};
      ge    = t >= {1'b0, d};
      n     = l;
      n.rem = ge ? hlfc_pkg::DEN_W'(t - {1'b0, d}) : t[hlfc_pkg::DEN_W-1:0];
      n.low = {l.low[hlfc_pkg::Q_W-2:0], 1'b0};
      n.q   = {l.q[hlfc_pkg::Q_W-2:0], ge};
      return n;
   endfunction

   always_comb begin
      start.l0   = lane_init(in_req.n0_mag, in_req.n0_neg, in_req.d);
      start.l1   = lane_init(in_req.n1_mag, in_req.n1_neg, in_req.d);
      start.d    = in_req.d;
      start.side = in_req.side;
   end

   for (genvar i = 0; i < hlfc_pkg::DIV_STEPS; i++) begin : g_step
      stage_type cur;
      stage_type nxt;
      logic      cur_valid;

      if (i == 0) begin : g_first
         assign cur       = start;
         assign cur_valid = in_valid;
      end else begin : g_next
         assign cur       = data_ff[i-1];
         assign cur_valid = valid_ff[i-1];
      end

      always_comb begin
         nxt    = cur;
         nxt.l0 = lane_step(cur.l0, cur.d);
         nxt.l1 = lane_step(cur.l1, cur.d);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            data_ff[i] <= nxt;
         end
      end
   end

   always_comb begin
      out_valid      = valid_ff[hlfc_pkg::DIV_STEPS-1];
      out_rsp.r0.q   = data_ff[hlfc_pkg::DIV_STEPS-1].l0.q;
      out_rsp.r0.ovf = data_ff[hlfc_pkg::DIV_STEPS-1].l0.ovf;
      out_rsp.r0.neg = data_ff[hlfc_pkg::DIV_STEPS-1].l0.neg;
      out_rsp.r1.q   = data_ff[hlfc_pkg::DIV_STEPS-1].l1.q;
      out_rsp.r1.ovf = data_ff[hlfc_pkg::DIV_STEPS-1].l1.ovf;
      out_rsp.r1.neg = data_ff[hlfc_pkg::DIV_STEPS-1].l1.neg;
      out_rsp.side   = data_ff[hlfc_pkg::DIV_STEPS-1].side;
   end

endmodule

FILE: hw/rtl/hough_line_frame_clip.sv
// Top level of the Hough line frame clipper: Hough line in, frame segment out.
//
// Each transfer on the req_ channel carries one Hough line, a signed Q12.4
// distance and a 16-bit binary angle; each produces exactly one transfer on
// the rsp_ channel with the Q16.16 slope, the Q20.4 intercept, the two
// endpoints where the line crosses the frame edges (all zero when it misses
// the frame) and a vertical flag. The block is a fully pipelined datapath:
// it takes a new line in every cycle unless the output is stalled. Each line
// passes through 1 input stage, 16 CORDIC stages, 1 stage, a 33-stage
// divider, 3 stages, a second 33-stage divider and 2 stages. The whole
// pipeline advances together and holds while the output register is full
// and stalled, so req_stall follows rsp_stall. The frame size registers are
// written through the csr_ port and must only change while no line is in
// flight.
module hough_line_frame_clip (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_distance,
   input  logic [15:0]        req_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_slope_out,
   output logic signed [23:0] rsp_intercept_out,
   output logic [15:0]        rsp_start_x,
   output logic [15:0]        rsp_start_y,
   output logic [15:0]        rsp_end_x,
   output logic [15:0]        rsp_end_y,
   output logic               rsp_vertical,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [11:0]        csr_wdata
);

   // Configuration registers.
   logic [11:0] frame_width_ff, frame_width_in;
   logic [11:0] frame_height_ff, frame_height_in;
   logic [15:0] w16;
   logic [15:0] h16;

   // The whole pipeline moves unless the output register holds a stalled result.
   logic advance;

   // Input stage.
   logic                      a_valid_ff, a_valid_in;
   logic [15:0]               a_theta_ff, a_theta_in;
   hlfc_pkg::cordic_side_type a_side_ff, a_side_in;

   // CORDIC output.
   logic                      cor_valid;
   hlfc_pkg::cordic_data_type cor_data;

   // Divider request for slope and intercept.
   logic                      b_valid_ff, b_valid_in;
   hlfc_pkg::div_request_type b_req_ff, b_req_in;

   logic                       div1_valid;
   hlfc_pkg::div_response_type div1_rsp;

   // Saturated slope and intercept.
   logic                   c_valid_ff, c_valid_in;
   hlfc_pkg::div_side_type c_side_ff, c_side_in;

   // Slope times frame width.
   logic                   d_valid_ff, d_valid_in;
   logic signed [48:0]     d_prod_ff, d_prod_in;
   hlfc_pkg::div_side_type d_side_ff;

   // Divider request for the x crossings.
   logic                      e_valid_ff, e_valid_in;
   hlfc_pkg::div_request_type e_req_ff, e_req_in;

   logic                       div2_valid;
   hlfc_pkg::div_response_type div2_rsp;

   // Crossings and comparison flags.
   logic                     f_valid_ff, f_valid_in;
   hlfc_pkg::ep_type         f_xh_ff, f_xh_in;
   hlfc_pkg::ep_type         f_x0_ff, f_x0_in;
   hlfc_pkg::clip_flags_type f_flags_ff, f_flags_in;
   hlfc_pkg::div_side_type   f_side_ff;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_slope_ff, rsp_slope_in;
   logic signed [23:0] rsp_intercept_ff, rsp_intercept_in;
   logic [15:0]        rsp_start_x_ff, rsp_start_x_in;
   logic [15:0]        rsp_start_y_ff, rsp_start_y_in;
   logic [15:0]        rsp_end_x_ff, rsp_end_x_in;
   logic [15:0]        rsp_end_y_ff, rsp_end_y_in;
   logic               rsp_vertical_ff, rsp_vertical_in;

   assign w16     = {frame_width_ff, 4'h0};
   assign h16     = {frame_height_ff, 4'h0};
   assign advance = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Register writes; indexes past the register list are ignored.
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write) begin
         unique case (csr_index)
            hlfc_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            hlfc_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= hlfc_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= hlfc_pkg::FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // A negative distance is made positive and the angle turned by half a circle.
   // Vertical lines are resolved here: only the endpoint test remains.
   always_comb begin
      logic neg;
      neg        = req_distance[15];
      a_valid_in = req_valid;
      a_theta_in = req_angle ^ {neg, 15'h0000};
      a_side_in.r = neg ? (17'd0 - 17'(req_distance)) : {1'b0, req_distance};
      a_side_in.vert = (a_theta_in[14:0] == 15'h0000);
      a_side_in.vhit = a_theta_in[15] ? (a_side_in.r == 17'd0)
                                      : (a_side_in.r <= {1'b0, w16});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_theta_ff <= a_theta_in;
         a_side_ff  <= a_side_in;
      end
   end

   hlfc_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (a_valid_ff),
      .in_theta  (a_theta_ff),
      .in_side   (a_side_ff),
      .out_valid (cor_valid),
      .out_data  (cor_data)
   );

   // Slope is -cos/sin and intercept r/sin. The CORDIC result is negated when
   // the angle was folded, so signs are worked out from the raw outputs and
   // the fold flag, and the dividers see magnitudes.
   always_comb begin
      logic                             x_neg, y_neg, x_zero, y_zero, s_neg;
      logic [hlfc_pkg::XY_W-1:0]        abs_x, abs_y;
      x_neg  = cor_data.x[hlfc_pkg::XY_W-1];
      y_neg  = cor_data.y[hlfc_pkg::XY_W-1];
      x_zero = (cor_data.x == '0);
      y_zero = (cor_data.y == '0);
      abs_x  = x_neg ? (hlfc_pkg::XY_W'(0) - cor_data.x) : cor_data.x;
      abs_y  = y_neg ? (hlfc_pkg::XY_W'(0) - cor_data.y) : cor_data.y;
      s_neg  = !y_zero && (y_neg != cor_data.flip);

      b_valid_in             = cor_valid;
      b_req_in.side          = '0;
      b_req_in.side.r        = cor_data.side.r;
      b_req_in.side.vert     = cor_data.side.vert;
      b_req_in.side.vhit     = cor_data.side.vhit;
      b_req_in.side.s_zero   = y_zero;
      b_req_in.side.c_zero   = x_zero;
      b_req_in.side.c_pos    = !x_zero && (x_neg == cor_data.flip);
      b_req_in.n0_mag        = {abs_x[31:0], 16'h0000};
      b_req_in.n0_neg        = b_req_in.side.c_pos ^ s_neg;
      b_req_in.n1_mag        = {1'b0, cor_data.side.r, 30'h0};
      b_req_in.n1_neg        = s_neg;
      b_req_in.d             = abs_y[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_req_ff <= b_req_in;
      end
   end

   hlfc_div u_div_slope (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (b_valid_ff),
      .in_req    (b_req_ff),
      .out_valid (div1_valid),
      .out_rsp   (div1_rsp)
   );

   // Saturate the quotients. A zero sine saturates the slope by the sign of
   // -cos and the intercept toward positive unless the distance is zero.
   always_comb begin
      hlfc_pkg::div_result_type qm, qb;
      qm         = div1_rsp.r0;
      qb         = div1_rsp.r1;
      c_valid_in = div1_valid;
      c_side_in  = div1_rsp.side;
      if (div1_rsp.side.s_zero) begin
         if (div1_rsp.side.c_zero) begin
            c_side_in.m = '0;
         end else if (div1_rsp.side.c_pos) begin
            c_side_in.m = hlfc_pkg::SLOPE_MIN;
         end else begin
            c_side_in.m = hlfc_pkg::SLOPE_MAX;
         end
         c_side_in.b = (div1_rsp.side.r != 17'd0) ? hlfc_pkg::INTERCEPT_MAX : '0;
      end else begin
         if (qm.neg) begin
            c_side_in.m = (qm.ovf || qm.q > 33'h080000000) ? hlfc_pkg::SLOPE_MIN
                                                            : signed'(32'(33'd0 - qm.q));
         end else begin
            c_side_in.m = (qm.ovf || qm.q > 33'h07FFFFFFF) ? hlfc_pkg::SLOPE_MAX
                                                            : signed'(qm.q[31:0]);
         end
         if (qb.neg) begin
            c_side_in.b = (qb.ovf || qb.q > 33'h000800000) ? hlfc_pkg::INTERCEPT_MIN
                                                            : signed'(24'(33'd0 - qb.q));
         end else begin
            c_side_in.b = (qb.ovf || qb.q > 33'h0007FFFFF) ? hlfc_pkg::INTERCEPT_MAX
                                                            : signed'(qb.q[23:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_side_ff <= c_side_in;
      end
   end

   // Slope times the frame width in Q12.4, for the y crossing at the right edge.
   always_comb begin
      logic signed [16:0] w16s;
      w16s       = signed'({1'b0, w16});
      d_valid_in = c_valid_ff;
      d_prod_in  = c_side_ff.m * w16s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_prod_ff <= d_prod_in;
         d_side_ff <= c_side_ff;
      end
   end

   // y at the right edge, and the numerators for the x crossings at the
   // bottom edge, (H - b) / m, and at the top edge, -b / m.
   always_comb begin
      logic signed [24:0] hb;
      logic [24:0]        abs_hb;
      logic [23:0]        abs_b;
      logic [31:0]        abs_m;
      logic               m_neg, b_pos;
      hb     = signed'({9'h000, h16}) - 25'(d_side_ff.b);
      abs_hb = hb[24] ? (25'd0 - hb) : hb;
      abs_b  = d_side_ff.b[23] ? (24'd0 - d_side_ff.b) : d_side_ff.b;
      m_neg  = d_side_ff.m[31];
      abs_m  = m_neg ? (32'd0 - d_side_ff.m) : d_side_ff.m;
      b_pos  = !d_side_ff.b[23] && (d_side_ff.b != '0);

      e_valid_in       = d_valid_ff;
      e_req_in.side    = d_side_ff;
      e_req_in.side.y_w = 34'(d_prod_ff >>> 16) + 34'(d_side_ff.b);
      e_req_in.n0_mag  = {7'h00, abs_hb, 16'h0000};
      e_req_in.n0_neg  = hb[24] ^ m_neg;
      e_req_in.n1_mag  = {8'h00, abs_b, 16'h0000};
      e_req_in.n1_neg  = b_pos ^ m_neg;
      e_req_in.d       = abs_m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         e_valid_ff <= e_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_req_ff <= e_req_in;
      end
   end

   hlfc_div u_div_cross (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (e_valid_ff),
      .in_req    (e_req_ff),
      .out_valid (div2_valid),
      .out_rsp   (div2_rsp)
   );

   // Form the crossings and all comparisons against the frame edges.
   always_comb begin
      hlfc_pkg::ep_type w16e, h16e, be, ywe;
      w16e = hlfc_pkg::EP_W'(w16);
      h16e = hlfc_pkg::EP_W'(h16);
      be   = hlfc_pkg::EP_W'(div2_rsp.side.b);
      ywe  = hlfc_pkg::EP_W'(div2_rsp.side.y_w);

      f_valid_in = div2_valid;
      f_xh_in    = hlfc_pkg::div_to_ep(div2_rsp.r0);
      f_x0_in    = hlfc_pkg::div_to_ep(div2_rsp.r1);
      f_flags_in.m_zero  = (div2_rsp.side.m == '0);
      f_flags_in.m_pos   = !div2_rsp.side.m[31] && !f_flags_in.m_zero;
      f_flags_in.b_neg   = div2_rsp.side.b[23];
      f_flags_in.b_gt_h  = be > h16e;
      f_flags_in.yw_gt_h = ywe > h16e;
      f_flags_in.xh_gt_w = f_xh_in > w16e;
      f_flags_in.x0_gt_w = f_x0_in > w16e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (advance) begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f_xh_ff    <= f_xh_in;
         f_x0_ff    <= f_x0_in;
         f_flags_ff <= f_flags_in;
         f_side_ff  <= div2_rsp.side;
      end
   end

   // Pick the endpoints by the vertical flag, slope sign and where the intercept lies. A line
   // with negative slope and negative intercept, or any other line that does
   // not cross the frame, reports all four endpoints as zero.
   always_comb begin
      hlfc_pkg::ep_type w16e, h16e, be, ywe, sx, sy, ex, ey;
      logic             hit;
      w16e = hlfc_pkg::EP_W'(w16);
      h16e = hlfc_pkg::EP_W'(h16);
      be   = hlfc_pkg::EP_W'(f_side_ff.b);
      ywe  = hlfc_pkg::EP_W'(f_side_ff.y_w);
      sx   = '0;
      sy   = '0;
      ex   = '0;
      ey   = '0;
      hit  = 1'b1;

      if (f_side_ff.vert) begin
         if (f_side_ff.vhit) begin
            sx = hlfc_pkg::EP_W'(f_side_ff.r);
            ex = sx;
            ey = h16e;
         end
      end else if (f_flags_ff.m_zero) begin
         if (!f_flags_ff.b_neg && !f_flags_ff.b_gt_h) begin
            sy = be;
            ex = w16e;
            ey = be;
         end else begin
            hit = 1'b0;
         end
      end else if (!f_flags_ff.b_neg && f_flags_ff.m_pos) begin
         if (f_flags_ff.b_gt_h) begin
            hit = 1'b0;
         end else begin
            sy = be;
            if (f_flags_ff.yw_gt_h) begin
               ex = f_xh_ff;
               ey = h16e;
            end else begin
               ex = w16e;
               ey = ywe;
            end
         end
      end else if (!f_flags_ff.b_neg) begin
         if (f_flags_ff.b_gt_h && f_flags_ff.xh_gt_w) begin
            hit = 1'b0;
         end else begin
            if (f_flags_ff.x0_gt_w) begin
               ex = w16e;
               ey = ywe;
            end else begin
               ex = f_x0_ff;
            end
            if (f_flags_ff.b_gt_h) begin
               sx = f_xh_ff;
               sy = h16e;
            end else begin
               sy = be;
            end
         end
      end else if (f_flags_ff.m_pos) begin
         if (f_flags_ff.x0_gt_w) begin
            hit = 1'b0;
         end else begin
            sx = f_x0_ff;
            if (f_flags_ff.yw_gt_h) begin
               ex = f_xh_ff;
               ey = h16e;
            end else begin
               ex = w16e;
               ey = ywe;
            end
         end
      end else begin
         hit = 1'b0;
      end

      if (!hit) begin
         sx = '0;
         sy = '0;
         ex = '0;
         ey = '0;
      end

      rsp_valid_in     = f_valid_ff;
      rsp_slope_in     = f_side_ff.vert ? hlfc_pkg::VERT_SLOPE : f_side_ff.m;
      rsp_intercept_in = f_side_ff.vert ? hlfc_pkg::VERT_INTERCEPT : f_side_ff.b;
      rsp_start_x_in   = hlfc_pkg::coord_clip(sx);
      rsp_start_y_in   = hlfc_pkg::coord_clip(sy);
      rsp_end_x_in     = hlfc_pkg::coord_clip(ex);
      rsp_end_y_in     = hlfc_pkg::coord_clip(ey);
      rsp_vertical_in  = f_side_ff.vert;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_slope_ff     <= rsp_slope_in;
         rsp_intercept_ff <= rsp_intercept_in;
         rsp_start_x_ff   <= rsp_start_x_in;
         rsp_start_y_ff   <= rsp_start_y_in;
         rsp_end_x_ff     <= rsp_end_x_in;
         rsp_end_y_ff     <= rsp_end_y_in;
         rsp_vertical_ff  <= rsp_vertical_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slope_out     = rsp_slope_ff;
   assign rsp_intercept_out = rsp_intercept_ff;
   assign rsp_start_x       = rsp_start_x_ff;
   assign rsp_start_y       = rsp_start_y_ff;
   assign rsp_end_x         = rsp_end_x_ff;
   assign rsp_end_y         = rsp_end_y_ff;
   assign rsp_vertical      = rsp_vertical_ff;

endmodule
